### rtl/core/pic_pkg.sv
// shared constants, command codes and types of the platform interrupt controller
package pic_pkg;

    localparam int NUM_SOURCES   = 1024;
    localparam int PRIORITY_BITS = 3;
    localparam int SRC_W         = 10;
    localparam int WORD_W        = 5;
    localparam int NUM_WORDS     = 32;
    localparam int OP_W          = 4;

    // word addresses (byte offset >> 2)
    localparam logic [23:0] PEND_BASE = 24'h000400;
    localparam logic [23:0] EN_BASE   = 24'h000800;
    localparam logic [23:0] THR_WORD  = 24'h080000;
    localparam logic [23:0] CLM_WORD  = 24'h080001;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_REQ   = 2'd2;

    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_RD_PRIO  = 4'd1;
    localparam logic [OP_W-1:0] OP_RD_PEND  = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_EN    = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_THR   = 4'd4;
    localparam logic [OP_W-1:0] OP_CLAIM    = 4'd5;
    localparam logic [OP_W-1:0] OP_WR_PRIO  = 4'd6;
    localparam logic [OP_W-1:0] OP_WR_EN    = 4'd7;
    localparam logic [OP_W-1:0] OP_WR_THR   = 4'd8;
    localparam logic [OP_W-1:0] OP_COMPLETE = 4'd9;
    localparam logic [OP_W-1:0] OP_REQ      = 4'd10;
    localparam logic [OP_W-1:0] OP_CAPPLY   = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SRC_W-1:0] idx;
        logic [31:0]      data;
    } t_cmd;

endpackage

### rtl/core/pic_front.sv
// front end: decodes requests and queues them for the back end
module pic_front import pic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [25:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [9:0]  i_source_id,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    logic [23:0] word;
    t_cmd        dec;
    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, pop;

    assign word = i_address[25:2];

    always_comb begin
        dec.op   = OP_NOP;
        dec.idx  = word[SRC_W-1:0];
        dec.data = i_write_data;
        case (i_action)
            ACT_READ: begin
                if (word[23:SRC_W] == '0) begin
                    if (word[SRC_W-1:0] != '0) dec.op = OP_RD_PRIO;
                end else if (word[23:WORD_W] == PEND_BASE[23:WORD_W]) begin
                    dec.op = OP_RD_PEND;
                end else if (word[23:WORD_W] == EN_BASE[23:WORD_W]) begin
                    dec.op = OP_RD_EN;
                end else if (word == THR_WORD) begin
                    dec.op = OP_RD_THR;
                end else if (word == CLM_WORD) begin
                    dec.op = OP_CLAIM;
                end
            end
            ACT_WRITE: begin
                if (word[23:SRC_W] == '0) begin
                    if (word[SRC_W-1:0] != '0) dec.op = OP_WR_PRIO;
                end else if (word[23:WORD_W] == EN_BASE[23:WORD_W]) begin
                    dec.op = OP_WR_EN;
                end else if (word == THR_WORD) begin
                    dec.op = OP_WR_THR;
                end else if (word == CLM_WORD) begin
                    dec.idx = i_write_data[SRC_W-1:0];
                    if (i_write_data[31:SRC_W] == '0 && i_write_data[SRC_W-1:0] != '0)
                        dec.op = OP_COMPLETE;
                end
            end
            ACT_REQ: begin
                dec.idx = i_source_id;
                if (i_source_id != '0) dec.op = OP_REQ;
            end
            default: dec.op = OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= dec;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/core/pic_back.sv
// back end: sequencer over the source memories with the arbitration scan
module pic_back import pic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_EXEC2 = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_SDONE = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [SRC_W-1:0] LAST_ID = SRC_W'(NUM_SOURCES - 1);

    logic [PRIORITY_BITS-1:0] prio_mem [NUM_SOURCES];
    logic [31:0]              pend_mem [NUM_WORDS];
    logic [31:0]              en_mem   [NUM_WORDS];
    logic [31:0]              isv_mem  [NUM_WORDS];

    logic [2:0]               r_state;
    logic [OP_W-1:0]          r_op;
    logic [SRC_W-1:0]         r_idx;
    logic [31:0]              r_data;
    logic [SRC_W-1:0]         r_cnt;
    logic                     r_claim;
    logic                     r_sv;
    logic [SRC_W-1:0]         r_sid;
    logic [PRIORITY_BITS-1:0] r_bp;
    logic [SRC_W-1:0]         r_best;
    logic [PRIORITY_BITS-1:0] r_thr;
    logic [31:0]              r_rd;
    logic                     r_irq;

    logic [PRIORITY_BITS-1:0] prio_rd;
    logic [31:0]              pend_rd, en_rd, isv_rd;
    logic [SRC_W-1:0]         ra;
    logic [WORD_W-1:0]        wa_rd;
    logic                     word_op;
    logic [31:0]              bitm;

    logic                     prio_we, pend_we, en_we, isv_we;
    logic [SRC_W-1:0]         prio_wa;
    logic [WORD_W-1:0]        bits_wa;
    logic [PRIORITY_BITS-1:0] prio_wd;
    logic [31:0]              pend_wd, en_wd, isv_wd;
    logic                     hit;

    assign word_op = (r_op == OP_RD_PEND) || (r_op == OP_RD_EN) || (r_op == OP_WR_EN);
    assign ra      = (r_state == S_SCAN) ? r_cnt : r_idx;
    assign wa_rd   = (r_state == S_SCAN) ? r_cnt[SRC_W-1:WORD_W] :
                     (word_op ? r_idx[WORD_W-1:0] : r_idx[SRC_W-1:WORD_W]);
    assign bitm    = 32'd1 << r_idx[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        prio_rd <= prio_mem[ra];
        pend_rd <= pend_mem[wa_rd];
        en_rd   <= en_mem[wa_rd];
        isv_rd  <= isv_mem[wa_rd];
        if (prio_we) prio_mem[prio_wa] <= prio_wd;
        if (pend_we) pend_mem[bits_wa] <= pend_wd;
        if (en_we)   en_mem[bits_wa]   <= en_wd;
        if (isv_we)  isv_mem[bits_wa]  <= isv_wd;
    end

    always_comb begin
        prio_we = 1'b0;
        pend_we = 1'b0;
        en_we   = 1'b0;
        isv_we  = 1'b0;
        prio_wa = r_idx;
        bits_wa = r_idx[SRC_W-1:WORD_W];
        prio_wd = r_data[PRIORITY_BITS-1:0];
        pend_wd = pend_rd | bitm;
        en_wd   = r_data;
        isv_wd  = isv_rd & ~bitm;
        if (r_state == S_CLEAR) begin
            prio_we = 1'b1;
            prio_wa = r_cnt;
            prio_wd = '0;
            bits_wa = r_cnt[WORD_W-1:0];
            pend_wd = '0;
            en_wd   = '0;
            isv_wd  = '0;
            pend_we = (r_cnt[SRC_W-1:WORD_W] == '0);
            en_we   = pend_we;
            isv_we  = pend_we;
        end else if (r_state == S_EXEC2) begin
            case (r_op)
                OP_WR_PRIO: prio_we = 1'b1;
                OP_WR_EN: begin
                    en_we   = 1'b1;
                    bits_wa = r_idx[WORD_W-1:0];
                    // source zero has no enable bit
                    en_wd   = (r_idx[WORD_W-1:0] == '0) ? {r_data[31:1], 1'b0} : r_data;
                end
                OP_COMPLETE: isv_we = 1'b1;
                OP_REQ: pend_we = ((pend_rd & bitm) == '0) && ((isv_rd & bitm) == '0);
                OP_CAPPLY: begin
                    pend_we = 1'b1;
                    pend_wd = pend_rd & ~bitm;
                    isv_we  = 1'b1;
                    isv_wd  = isv_rd | bitm;
                end
                default: ;
            endcase
        end
    end

    assign hit         = r_sv && pend_rd[r_sid[WORD_W-1:0]] && en_rd[r_sid[WORD_W-1:0]] &&
                         (prio_rd > r_bp);
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_read_data = r_rd;
    assign o_irq_out   = r_irq;

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_bp   <= prio_rd;
            r_best <= r_sid;
        end
        r_sid <= r_cnt;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_thr   <= '0;
            r_sv    <= 1'b0;
            r_claim <= 1'b0;
        end else begin
            r_sv <= (r_state == S_SCAN);
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ID) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op    <= i_cmd.op;
                        r_idx   <= i_cmd.idx;
                        r_data  <= i_cmd.data;
                        r_rd    <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_CLAIM) begin
                        r_claim <= 1'b1;
                        r_cnt   <= SRC_W'(1);
                        r_bp    <= r_thr;
                        r_best  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_EXEC2;
                    end
                end
                S_EXEC2: begin
                    case (r_op)
                        OP_RD_PRIO: r_rd <= 32'(prio_rd);
                        OP_RD_PEND: r_rd <= pend_rd;
                        OP_RD_EN:   r_rd <= en_rd;
                        OP_RD_THR:  r_rd <= 32'(r_thr);
                        OP_WR_THR:  r_thr <= r_data[PRIORITY_BITS-1:0];
                        default: ;
                    endcase
                    r_claim <= 1'b0;
                    r_cnt   <= SRC_W'(1);
                    r_bp    <= (r_op == OP_WR_THR) ? r_data[PRIORITY_BITS-1:0] : r_thr;
                    r_best  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ID) r_state <= S_DRAIN;
                end
                S_DRAIN: r_state <= S_SDONE;
                S_SDONE: begin
                    if (r_claim) begin
                        r_claim <= 1'b0;
                        r_rd    <= 32'(r_best);
                        if (r_best != '0) begin
                            r_idx   <= r_best;
                            r_op    <= OP_CAPPLY;
                            r_state <= S_EXEC;
                        end else begin
                            r_irq   <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_irq   <= (r_best != '0);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/platform_interrupt_controller_top.sv
// top level of the single-context platform interrupt controller
// a claim read that finds a source runs a second scan after it applies the claim
// the back end takes one request at a time and runs a scan of all sources in pic_back for each
// the scan reads one source per cycle from the priority memory and bit-word memories
// reset: synchronous active-low; a clearing pass over all 1024 sources follows reset, during
// which the back end takes no request; the two-entry queue in front can hold two meanwhile
module platform_interrupt_controller_top import pic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [25:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [9:0]  i_source_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_out
);

    // decoded request path between front and back
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    // front: address decode and request queue
    pic_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_source_id  (i_source_id),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    // back: memories, read-modify-write and arbitration scan, result register
    pic_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .o_irq_out   (o_irq_out)
    );

endmodule

### tb/sv/platform_interrupt_controller_checker.sv
// request and result checker with a built-in model of the interrupt controller
module platform_interrupt_controller_checker import pic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [25:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [9:0]  i_source_id,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_read_data,
    input  logic        i_irq_out,
    output int          o_fail_count,
    output int          o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PRIORITY_BITS-1:0] prio_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]   pend_bits;
    logic [NUM_SOURCES-1:0]   en_bits;
    logic [NUM_SOURCES-1:0]   svc_bits;
    logic [PRIORITY_BITS-1:0] threshold;

    logic [31:0] read_data_q [$];
    logic        irq_q [$];

    initial begin
        foreach (prio_mem[i]) prio_mem[i] = '0;
        pend_bits    = '0;
        en_bits      = '0;
        svc_bits     = '0;
        threshold    = '0;
        o_fail_count = 0;
    end

    assign o_results_owed = read_data_q.size();

    // highest qualifying priority wins, lowest id on a tie
    function automatic int unsigned winning_source();
        int unsigned best;
        logic [PRIORITY_BITS-1:0] best_prio;
        best = 0;
        best_prio = threshold;
        for (int id = 1; id < NUM_SOURCES; id++) begin
            if (pend_bits[id] && en_bits[id] && prio_mem[id] > best_prio) begin
                best_prio = prio_mem[id];
                best = id;
            end
        end
        return best;
    endfunction

    function automatic logic [31:0] bit_word(logic [NUM_SOURCES-1:0] bits, int w);
        logic [31:0] v;
        v = bits[w*32 +: 32];
        if (w == 0) v[0] = 1'b0;
        return v;
    endfunction

    task automatic predict_request(logic [1:0] act, logic [25:0] addr, logic [31:0] data,
                                   logic [9:0] src);
        logic [23:0] word;
        logic [31:0] rd;
        int unsigned id;
        word = addr[25:2];
        rd = '0;
        if (act == ACT_READ) begin
            if (word < NUM_SOURCES) begin
                rd = (word == 0) ? '0 : 32'(prio_mem[word]);
            end else if (word >= PEND_BASE && word < PEND_BASE + NUM_WORDS) begin
                rd = bit_word(pend_bits, int'(word - PEND_BASE));
            end else if (word >= EN_BASE && word < EN_BASE + NUM_WORDS) begin
                rd = bit_word(en_bits, int'(word - EN_BASE));
            end else if (word == THR_WORD) begin
                rd = 32'(threshold);
            end else if (word == CLM_WORD) begin
                id = winning_source();
                if (id != 0) begin
                    pend_bits[id] = 1'b0;
                    svc_bits[id]  = 1'b1;
                end
                rd = id;
            end
        end else if (act == ACT_WRITE) begin
            if (word < NUM_SOURCES) begin
                if (word != 0) prio_mem[word] = data[PRIORITY_BITS-1:0];
            end else if (word >= EN_BASE && word < EN_BASE + NUM_WORDS) begin
                en_bits[int'(word - EN_BASE)*32 +: 32] = data;
                en_bits[0] = 1'b0;
            end else if (word == THR_WORD) begin
                threshold = data[PRIORITY_BITS-1:0];
            end else if (word == CLM_WORD) begin
                if (data >= 1 && data < NUM_SOURCES) svc_bits[data[SRC_W-1:0]] = 1'b0;
            end
        end else if (act == ACT_REQ) begin
            if (src != 0 && !pend_bits[src] && !svc_bits[src]) pend_bits[src] = 1'b1;
        end
        read_data_q.push_back(rd);
        irq_q.push_back(winning_source() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                predict_request(i_action, i_address, i_write_data, i_source_id);
            if (i_out_valid && i_out_ready) begin
                if (read_data_q.size() == 0) begin
                    $display("%0t: result with nothing expected: read_data %h irq %b",
                             $time, i_read_data, i_irq_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (read_data_q[0] !== i_read_data || irq_q[0] !== i_irq_out) begin
                        $display("%0t: mismatch: expected read_data %h irq %b, got %h %b",
                                 $time, read_data_q[0], irq_q[0], i_read_data, i_irq_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(read_data_q.pop_front());
                    void'(irq_q.pop_front());
                end
            end
        end
    end

endmodule

### tb/sv/platform_interrupt_controller_top_test.sv
// stimulus, handshake pacing and verdict for the platform interrupt controller
module platform_interrupt_controller_top_test;
    import pic_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // byte addresses of the register map
    localparam logic [25:0] PRIO_ADDR  = 26'h0000000;
    localparam logic [25:0] PEND_ADDR  = 26'h0001000;
    localparam logic [25:0] EN_ADDR    = 26'h0002000;
    localparam logic [25:0] THR_ADDR   = 26'h0200000;
    localparam logic [25:0] CLAIM_ADDR = 26'h0200004;
    // spare action code, the block does nothing with it
    localparam logic [1:0]  ACT_SPARE  = 2'd3;

    localparam int RANDOM_REQUESTS = 555;
    localparam int HOLD_CYCLES     = 4000;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int DRAIN_CYCLES    = 2200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [25:0] i_address;
    logic [31:0] i_write_data;
    logic [9:0]  i_source_id;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_read_data;
    logic        o_irq_out;

    int fail_count;
    int results_owed;
    bit steady_run;   // no idling on either side while set
    bit hold_results; // receiver backs off for a long stretch when set

    platform_interrupt_controller_top dut (.*);

    platform_interrupt_controller_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_action, .i_address, .i_write_data, .i_source_id,
        .i_out_valid(o_out_valid), .i_out_ready, .i_read_data(o_read_data),
        .i_irq_out(o_irq_out), .o_fail_count(fail_count), .o_results_owed(results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: too long without any request or result moving
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("platform_interrupt_controller_top_test failed");
                $finish;
            end
        end
    end

    // result side: random backpressure, one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                i_out_ready <= steady_run || ($urandom_range(99) >= 36);
            end
        end
    end

    // offer one request and wait for it to be taken; valid stays up afterwards
    task automatic send_request(logic [1:0] act, logic [25:0] addr, logic [31:0] data,
                                logic [9:0] src);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_address    <= addr;
        i_write_data <= data;
        i_source_id  <= src;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic maybe_idle();
        if (!steady_run && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // source id biased toward the low ids so claims keep finding work
    function automatic logic [9:0] pick_source();
        return ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(63));
    endfunction

    task automatic random_request();
        int roll;
        logic [25:0] addr;
        roll = $urandom_range(99);
        addr = 26'($urandom_range(3));
        if (roll < 30) begin
            send_request(ACT_REQ, 26'($urandom), $urandom, pick_source());
        end else if (roll < 45) begin
            send_request(ACT_READ, CLAIM_ADDR | addr, $urandom, 10'($urandom));
        end else if (roll < 55) begin
            // mostly real ids, sometimes a wild completion
            send_request(ACT_WRITE, CLAIM_ADDR | addr,
                         ($urandom_range(4) == 0) ? $urandom : 32'(pick_source()),
                         10'($urandom));
        end else if (roll < 70) begin
            send_request(ACT_WRITE, PRIO_ADDR | {14'd0, pick_source(), 2'b00} | addr,
                         $urandom, 10'($urandom));
        end else if (roll < 78) begin
            send_request(ACT_WRITE, EN_ADDR | {19'd0, 5'($urandom_range(31)), 2'b00} | addr,
                         ($urandom_range(1) == 0) ? 32'hffff_ffff : $urandom, 10'($urandom));
        end else if (roll < 83) begin
            send_request(ACT_WRITE, THR_ADDR | addr, $urandom, 10'($urandom));
        end else if (roll < 93) begin
            case ($urandom_range(3))
                0: addr |= PRIO_ADDR | {14'd0, pick_source(), 2'b00};
                1: addr |= PEND_ADDR | {19'd0, 5'($urandom_range(31)), 2'b00};
                2: addr |= EN_ADDR | {19'd0, 5'($urandom_range(31)), 2'b00};
                default: addr |= THR_ADDR;
            endcase
            send_request(ACT_READ, addr, $urandom, 10'($urandom));
        end else begin
            // noise: anywhere in the window, any action including the spare one
            send_request(2'($urandom), 26'($urandom), $urandom, 10'($urandom));
        end
    endtask

    initial begin
        steady_run   = 1'b0;
        hold_results = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_READ;
        i_address    <= '0;
        i_write_data <= '0;
        i_source_id  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, source zero, extremes, claim order, bad completions
        send_request(ACT_READ, CLAIM_ADDR, '0, '0);
        send_request(ACT_READ, PRIO_ADDR, '0, '0);
        send_request(ACT_WRITE, PRIO_ADDR, 32'hffff_ffff, '0);
        send_request(ACT_WRITE, PRIO_ADDR | 26'hffc, 32'hffff_ffff, '0);
        send_request(ACT_READ, PRIO_ADDR | 26'hffc, '0, '0);
        send_request(ACT_WRITE, PRIO_ADDR | 26'h004, 32'h0000_0003, '0);
        send_request(ACT_WRITE, EN_ADDR, 32'hffff_ffff, '0);
        send_request(ACT_WRITE, EN_ADDR | 26'h07c, 32'hffff_ffff, '0);
        send_request(ACT_WRITE, THR_ADDR, 32'hffff_fffa, '0);
        send_request(ACT_REQ, '0, '0, 10'd0);
        send_request(ACT_REQ, '0, '0, 10'd1);
        send_request(ACT_REQ, 26'h3ff_ffff, 32'hffff_ffff, 10'h3ff);
        send_request(ACT_REQ, '0, '0, 10'd1);
        send_request(ACT_READ, PEND_ADDR, '0, '0);
        send_request(ACT_WRITE, PEND_ADDR, 32'hffff_ffff, '0);
        send_request(ACT_READ, CLAIM_ADDR, '0, '0);
        send_request(ACT_READ, CLAIM_ADDR | 26'h3, '0, '0);
        send_request(ACT_REQ, '0, '0, 10'd1);
        send_request(ACT_WRITE, CLAIM_ADDR, 32'd0, '0);
        send_request(ACT_WRITE, CLAIM_ADDR, 32'hffff_ffff, '0);
        send_request(ACT_WRITE, CLAIM_ADDR, 32'd1023, '0);
        send_request(ACT_WRITE, CLAIM_ADDR, 32'd1, '0);
        send_request(ACT_READ, 26'h3ff_fffc, '0, '0);
        send_request(ACT_WRITE, 26'h3ff_fffc, 32'hffff_ffff, '0);
        send_request(ACT_READ, EN_ADDR | 26'h3, '0, '0);
        send_request(ACT_SPARE, CLAIM_ADDR, 32'hffff_ffff, 10'h3ff);
        send_request(ACT_WRITE, THR_ADDR, 32'd7, '0);
        send_request(ACT_READ, THR_ADDR, '0, '0);
        send_request(ACT_WRITE, THR_ADDR, 32'd0, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            steady_run = (n >= 200 && n < 280);
            if (n == 100) hold_results = 1'b1; // block fills up while results wait
            if (n == 350) begin
                // sender stays quiet until everything owed has come back
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                wait (results_owed == 0);
                @(posedge i_clk);
            end
            random_request();
            maybe_idle();
        end
        i_in_valid <= 1'b0;
        steady_run = 1'b0;

        // let the checker log the last request before counting what is owed
        @(posedge i_clk);
        wait (results_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("platform_interrupt_controller_top_test passed");
        end else begin
            $display("platform_interrupt_controller_top_test failed");
        end
        $finish;
    end

endmodule
